@@ src/ppg_pkg.sv @@
package ppg_pkg;

  localparam int COORD_W      = 7;
  localparam int PHASE_W      = 9;
  localparam int SINE_ENTRIES = 1 << PHASE_W;
  localparam int SINE_W       = 12;
  localparam int SUM_W        = SINE_W + 2;
  localparam int COLOR_W      = 8;
  localparam int CFG_ADDR_W   = 5;
  localparam int CFG_DATA_W   = 32;

  // angle rounding and series constants for building the sine table
  localparam logic [63:0] SINE_Q      = 64'(SINE_ENTRIES) * 64'd10000000;
  localparam logic [63:0] PI_Q60      = 64'h3243F6A8885A308D;
  localparam logic [63:0] HALF_PI_Q60 = 64'h1921FB54442D1846;

  typedef enum logic [2:0] {
    REG_COL_STEP_A    = 3'd0,
    REG_COL_STEP_B    = 3'd1,
    REG_ROW_STEP_C    = 3'd2,
    REG_ROW_STEP_D    = 3'd3,
    REG_FRAME_STEP_A  = 3'd4,
    REG_FRAME_STEP_C  = 3'd5,
    REG_START_PHASE_B = 3'd6,
    REG_START_PHASE_D = 3'd7
  } cfg_reg_t;

  typedef enum logic [1:0] {
    SEG_RISE = 2'd0,
    SEG_HIGH = 2'd1,
    SEG_FALL = 2'd2,
    SEG_LOW  = 2'd3
  } pal_seg_t;

  typedef struct packed {
    logic [COORD_W-1:0] row;
    logic [COORD_W-1:0] column;
    logic               frame_end;
  } in_item_t;

  typedef struct packed {
    logic [COLOR_W-1:0] red;
    logic [COLOR_W-1:0] green;
    logic [COLOR_W-1:0] palette_index;
  } out_item_t;

  function automatic logic [63:0] mul_q60(input logic [63:0] a, input logic [63:0] b);
    logic [127:0] prod;
    prod = {64'd0, a} * {64'd0, b};
    return prod[123:60];
  endfunction

  // sine table entry, evaluated at elaboration only
  function automatic logic signed [SINE_W-1:0] sine_entry(input int unsigned pos);
    logic [63:0] p, num, m, r, x, x2, term, s, val, mask, half, qq, rem;
    int unsigned k, n, b, sh;
    logic neg, sub;
    p    = 64'(pos) * 64'd360 * 64'd174532;
    neg  = 1'b0;
    sub  = 1'b1;
    k    = 21;
    if (p == 64'd0) return '0;
    // round the angle to a 24-bit mantissa
    while (k < 59 && (p << k) < (SINE_Q << 23)) k++;
    num = p << k;
    m   = num / SINE_Q;
    r   = num % SINE_Q;
    if ((r << 1) > SINE_Q || ((r << 1) == SINE_Q && m[0])) m++;
    x = m << (60 - k);
    if (x >= PI_Q60) begin
      x   = x - PI_Q60;
      neg = 1'b1;
    end
    if (x > HALF_PI_Q60) x = (x <= PI_Q60) ? PI_Q60 - x : 64'd0;
    x2   = mul_q60(x, x);
    term = x;
    s    = x;
    for (n = 1; n <= 27; n += 2) begin
      term = mul_q60(term, x2) / 64'((n + 1) * (n + 2));
      if (sub) s = (s >= term) ? s - term : 64'd0;
      else     s = s + term;
      sub = !sub;
    end
    if (s == 64'd0) return '0;
    b = 63;
    while (s[b] == 1'b0) b--;
    if (b > 23) begin
      sh   = b - 23;
      mask = (64'd1 << sh) - 64'd1;
      half = 64'd1 << (sh - 1);
      qq   = s >> sh;
      rem  = s & mask;
      if (rem > half || (rem == half && qq[0])) qq++;
      s = qq << sh;
    end
    val = s >> 50;
    return neg ? -SINE_W'(val) : SINE_W'(val);
  endfunction

endpackage

@@ src/ppg_if.sv @@
interface ppg_in_if import ppg_pkg::*; ();
  logic     valid;
  logic     ready;
  in_item_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface ppg_out_if import ppg_pkg::*; ();
  logic      valid;
  logic      ready;
  out_item_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

@@ src/ppg_sine_rom.sv @@
module ppg_sine_rom import ppg_pkg::*; (
  input  logic                     clk,
  input  logic                     en,
  input  logic [PHASE_W-1:0]       addr_a,
  input  logic [PHASE_W-1:0]       addr_b,
  output logic signed [SINE_W-1:0] data_a,
  output logic signed [SINE_W-1:0] data_b
);

  logic signed [SINE_W-1:0] rom_w [SINE_ENTRIES];

  for (genvar g = 0; g < SINE_ENTRIES; g++) begin : g_entry
    localparam logic signed [SINE_W-1:0] VALUE = sine_entry(g);
    assign rom_w[g] = VALUE;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      data_a <= rom_w[addr_a];
      data_b <= rom_w[addr_b];
    end
  end

endmodule

@@ src/plasma_pixel_generator_top.sv @@
// Plasma pixel generator: one pixel word (row, column, frame_end) in, one palette word
// (red, green, palette_index) out. It takes a word every clock while the output word is not stalled;
// its result passes through the input register, the registered sine table read and the output
// register before it is offered on the output.
// The whole pipe holds only when the output word is stalled. The two frame phases step after
// a word with frame_end set leaves the first stage. Step and origin registers sit on the APB
// port at byte address 4*i and should be written only while the pipe is empty.
module plasma_pixel_generator_top import ppg_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  ppg_in_if.sink                in_ch,
  ppg_out_if.source             out_ch,
  input  logic                  cfg_psel,
  input  logic                  cfg_penable,
  input  logic                  cfg_pwrite,
  input  logic [CFG_ADDR_W-1:0] cfg_paddr,
  input  logic [CFG_DATA_W-1:0] cfg_pwdata,
  output logic [CFG_DATA_W-1:0] cfg_prdata,
  output logic                  cfg_pready
);

  logic [PHASE_W-1:0] col_step_a_r, col_step_b_r, row_step_c_r, row_step_d_r;
  logic [PHASE_W-1:0] frame_step_a_r, frame_step_c_r, start_phase_b_r, start_phase_d_r;
  logic [PHASE_W-1:0] frame_phase_a_r, frame_phase_c_r;
  logic [PHASE_W-1:0] frame_phase_a_nxt, frame_phase_c_nxt;

  logic      s1_vld_r, s2_vld_r, out_vld_r;
  in_item_t  s1_r;
  out_item_t out_data_r, out_data_nxt;
  logic      advance;
  logic      frame_adv;

  logic                     cfg_wr;
  cfg_reg_t                 cfg_sel;
  logic [PHASE_W-1:0]       cfg_val;
  logic [PHASE_W-1:0]       cfg_rd;

  logic [COORD_W:0]         col_p1;
  logic [PHASE_W-1:0]       phase_a, phase_b, phase_c, phase_d;
  logic signed [SINE_W-1:0] sine_a, sine_b, sine_c, sine_d;
  logic signed [SUM_W-1:0]  sum;
  logic [COLOR_W-1:0]       idx;
  logic [COLOR_W-1:0]       k4;

  // ---------------- configuration port
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite;
  assign cfg_sel    = cfg_reg_t'(cfg_paddr[CFG_ADDR_W-1:2]);
  assign cfg_val    = cfg_pwdata[PHASE_W-1:0];
  assign cfg_pready = 1'b1;
  assign cfg_prdata = CFG_DATA_W'(cfg_rd);

  always_comb begin
    case (cfg_sel)
      REG_COL_STEP_A:    cfg_rd = col_step_a_r;
      REG_COL_STEP_B:    cfg_rd = col_step_b_r;
      REG_ROW_STEP_C:    cfg_rd = row_step_c_r;
      REG_ROW_STEP_D:    cfg_rd = row_step_d_r;
      REG_FRAME_STEP_A:  cfg_rd = frame_step_a_r;
      REG_FRAME_STEP_C:  cfg_rd = frame_step_c_r;
      REG_START_PHASE_B: cfg_rd = start_phase_b_r;
      REG_START_PHASE_D: cfg_rd = start_phase_d_r;
      default:           cfg_rd = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_step_a_r    <= PHASE_W'(5);
      col_step_b_r    <= PHASE_W'(3);
      row_step_c_r    <= PHASE_W'(1);
      row_step_d_r    <= PHASE_W'(3);
      frame_step_a_r  <= PHASE_W'(9);
      frame_step_c_r  <= PHASE_W'(8);
      start_phase_b_r <= '0;
      start_phase_d_r <= '0;
    end else if (cfg_wr) begin
      case (cfg_sel)
        REG_COL_STEP_A:    col_step_a_r    <= cfg_val;
        REG_COL_STEP_B:    col_step_b_r    <= cfg_val;
        REG_ROW_STEP_C:    row_step_c_r    <= cfg_val;
        REG_ROW_STEP_D:    row_step_d_r    <= cfg_val;
        REG_FRAME_STEP_A:  frame_step_a_r  <= cfg_val;
        REG_FRAME_STEP_C:  frame_step_c_r  <= cfg_val;
        REG_START_PHASE_B: start_phase_b_r <= cfg_val;
        REG_START_PHASE_D: start_phase_d_r <= cfg_val;
        default: ;
      endcase
    end
  end

  // ---------------- pipe control: every stage moves together
  assign advance      = !out_vld_r || out_ch.ready;
  assign in_ch.ready  = advance;
  assign out_ch.valid = out_vld_r;
  assign out_ch.data  = out_data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r  <= 1'b0;
      s2_vld_r  <= 1'b0;
      out_vld_r <= 1'b0;
    end else if (advance) begin
      s1_vld_r  <= in_ch.valid;
      s2_vld_r  <= s1_vld_r;
      out_vld_r <= s2_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      s1_r       <= in_ch.data;
      out_data_r <= out_data_nxt;
    end
  end

  // ---------------- stage 1: phases and frame origin update
  assign col_p1  = {1'b0, s1_r.column} + (COORD_W+1)'(1);
  assign phase_a = frame_phase_a_r + PHASE_W'(col_step_a_r * col_p1);
  assign phase_b = start_phase_b_r + PHASE_W'(col_step_b_r * col_p1);
  assign phase_c = frame_phase_c_r + PHASE_W'(row_step_c_r * s1_r.row);
  assign phase_d = start_phase_d_r + PHASE_W'(row_step_d_r * s1_r.row);

  assign frame_adv = advance && s1_vld_r && s1_r.frame_end;

  always_comb begin
    frame_phase_a_nxt = frame_phase_a_r;
    frame_phase_c_nxt = frame_phase_c_r;
    if (frame_adv) begin
      frame_phase_a_nxt = frame_phase_a_r + frame_step_a_r;
      frame_phase_c_nxt = frame_phase_c_r + frame_step_c_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frame_phase_a_r <= '0;
      frame_phase_c_r <= '0;
    end else begin
      frame_phase_a_r <= frame_phase_a_nxt;
      frame_phase_c_r <= frame_phase_c_nxt;
    end
  end

  ppg_sine_rom u_rom_col (
    .clk    (clk),
    .en     (advance),
    .addr_a (phase_a),
    .addr_b (phase_b),
    .data_a (sine_a),
    .data_b (sine_b)
  );

  ppg_sine_rom u_rom_row (
    .clk    (clk),
    .en     (advance),
    .addr_a (phase_c),
    .addr_b (phase_d),
    .data_a (sine_c),
    .data_b (sine_d)
  );

  // ---------------- stage 2: sum, index and palette
  assign sum = SUM_W'(sine_a) + SUM_W'(sine_b) + SUM_W'(sine_c) + SUM_W'(sine_d);
  // floor(sum/16) + 128, modulo 256
  assign idx = sum[11:4] + COLOR_W'(128);
  assign k4  = {idx[5:0], 2'b00};

  always_comb begin
    out_data_nxt.palette_index = idx;
    case (pal_seg_t'(idx[7:6]))
      SEG_RISE: begin
        out_data_nxt.red   = k4;
        out_data_nxt.green = COLOR_W'(254) - k4;
      end
      SEG_HIGH: begin
        out_data_nxt.red   = COLOR_W'(255);
        out_data_nxt.green = k4 + COLOR_W'(1);
      end
      SEG_FALL: begin
        out_data_nxt.red   = COLOR_W'(254) - k4;
        out_data_nxt.green = COLOR_W'(254) - k4;
      end
      default: begin
        out_data_nxt.red   = '0;
        out_data_nxt.green = k4 + COLOR_W'(1);
      end
    endcase
  end

  // ---------------- checks
  a_phase_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !frame_adv |=> $stable(frame_phase_a_r) && $stable(frame_phase_c_r))
    else $error("frame phase moved without a frame end word");

  a_stage2_kept: assert property (@(posedge clk) disable iff (!rst_n)
    s2_vld_r && !advance |=> s2_vld_r)
    else $error("word in table read stage dropped during stall");

  a_pal_high: assert property (@(posedge clk) disable iff (!rst_n)
    out_vld_r && out_data_r.palette_index[7:6] == SEG_HIGH |-> out_data_r.red == 8'hff)
    else $error("palette high segment red not full");

  a_pal_low: assert property (@(posedge clk) disable iff (!rst_n)
    out_vld_r && out_data_r.palette_index[7:6] == SEG_LOW
      |-> out_data_r.red == 8'h00 && out_data_r.green[0])
    else $error("palette low segment mismatch");

endmodule

@@ tb/sv/plasma_pixel_generator_top_tb.sv @@
`timescale 1ns / 1ps

module plasma_pixel_generator_top_tb import ppg_pkg::*; ();

  typedef enum logic {DIR_PIXEL, DIR_WRITE} dir_op_t;
  typedef enum int {IDLE_NONE, IDLE_SRC, IDLE_SNK, IDLE_BOTH} idle_mode_t;

  typedef struct packed {
    dir_op_t   op;
    cfg_reg_t  sel;
    logic [31:0] wdata;
    in_item_t  px;
    logic      typed;
    out_item_t want;
  } dir_row_t;

  localparam int DIR_ROWS     = 40;
  localparam int PHASES       = 8;
  localparam int PHASE_PIXELS = 220;
  localparam int LONG_HOLD    = 150;
  localparam int PIPE_SETTLE  = 6;
  localparam out_item_t NO_WANT = '0;
  localparam out_item_t FLAT    = '{8'd254, 8'd254, 8'd128};

  logic clk;
  logic rst_n;
  logic                  cfg_psel;
  logic                  cfg_penable;
  logic                  cfg_pwrite;
  logic [CFG_ADDR_W-1:0] cfg_paddr;
  logic [CFG_DATA_W-1:0] cfg_pwdata;
  logic [CFG_DATA_W-1:0] cfg_prdata;
  logic                  cfg_pready;

  ppg_in_if  in_ch ();
  ppg_out_if out_ch ();

  plasma_pixel_generator_top DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_ch      (in_ch),
    .out_ch     (out_ch),
    .cfg_psel   (cfg_psel),
    .cfg_penable(cfg_penable),
    .cfg_pwrite (cfg_pwrite),
    .cfg_paddr  (cfg_paddr),
    .cfg_pwdata (cfg_pwdata),
    .cfg_prdata (cfg_prdata),
    .cfg_pready (cfg_pready)
  );

  // shadow of the block: step/origin registers, frame phases, sine table
  logic [PHASE_W-1:0] plasma_reg [8];
  logic [PHASE_W-1:0] frame_a;
  logic [PHASE_W-1:0] frame_c;
  int                 sine_lut [SINE_ENTRIES];

  out_item_t pending_pixels [$];

  int fail_cnt = 0;
  int shown    = 0;
  int src_idle_pct = 0;
  int snk_stall_pct = 0;
  bit hold_req = 1'b0;
  int hold_left = 0;

  dir_row_t dir_tab [DIR_ROWS] = '{
    '{DIR_PIXEL, REG_COL_STEP_A,    32'd0,         '{7'd0,   7'd0,   1'b0}, 1'b0, NO_WANT},
    '{DIR_PIXEL, REG_COL_STEP_A,    32'd0,         '{7'd127, 7'd127, 1'b0}, 1'b0, NO_WANT},
    '{DIR_PIXEL, REG_COL_STEP_A,    32'd0,         '{7'd127, 7'd0,   1'b1}, 1'b0, NO_WANT},
    '{DIR_PIXEL, REG_COL_STEP_A,    32'd0,         '{7'd0,   7'd127, 1'b0}, 1'b0, NO_WANT},
    '{DIR_PIXEL, REG_COL_STEP_A,    32'd0,         '{7'd85,  7'd42,  1'b1}, 1'b0, NO_WANT},
    '{DIR_PIXEL, REG_COL_STEP_A,    32'd0,         '{7'd42,  7'd85,  1'b0}, 1'b0, NO_WANT},
    // upper bits of the write data are dropped
    '{DIR_WRITE, REG_COL_STEP_A,    32'hFFFF_FE00, '0, 1'b0, NO_WANT},
    '{DIR_WRITE, REG_COL_STEP_B,    32'h0000_0200, '0, 1'b0, NO_WANT},
    '{DIR_WRITE, REG_ROW_STEP_C,    32'd0,         '0, 1'b0, NO_WANT},
    '{DIR_WRITE, REG_ROW_STEP_D,    32'd0,         '0, 1'b0, NO_WANT},
    '{DIR_WRITE, REG_START_PHASE_B, 32'd0,         '0, 1'b0, NO_WANT},
    '{DIR_WRITE, REG_START_PHASE_D, 32'd0,         '0, 1'b0, NO_WANT},
    // frame phases sit at 18/16 here, these steps wrap them back to zero
    '{DIR_WRITE, REG_FRAME_STEP_A,  32'd494,       '0, 1'b0, NO_WANT},
    '{DIR_WRITE, REG_FRAME_STEP_C,  32'd496,       '0, 1'b0, NO_WANT},
    '{DIR_PIXEL, REG_COL_STEP_A,    32'd0,         '{7'd127, 7'd127, 1'b1}, 1'b0, NO_WANT},
    '{DIR_WRITE, REG_FRAME_STEP_A,  32'd0,         '0, 1'b0, NO_WANT},
    '{DIR_WRITE, REG_FRAME_STEP_C,  32'd0,         '0, 1'b0, NO_WANT},
    // all phases zero: sum 0, index 128
    '{DIR_PIXEL, REG_COL_STEP_A,    32'd0,         '{7'd0,   7'd0,   1'b1}, 1'b1, FLAT},
    '{DIR_PIXEL, REG_COL_STEP_A,    32'd0,         '{7'd127, 7'd127, 1'b0}, 1'b1, FLAT},
    // quarter turn: one table peak of +1024
    '{DIR_WRITE, REG_COL_STEP_A,    32'd128,       '0, 1'b0, NO_WANT},
    '{DIR_PIXEL, REG_COL_STEP_A,    32'd0,         '{7'd0,   7'd0,   1'b0}, 1'b1,
      '{8'd0, 8'd1, 8'd192}},
    '{DIR_WRITE, REG_COL_STEP_B,    32'd128,       '0, 1'b0, NO_WANT},
    '{DIR_PIXEL, REG_COL_STEP_A,    32'd0,         '{7'd5,   7'd0,   1'b0}, 1'b1,
      '{8'd0, 8'd254, 8'd0}},
    '{DIR_PIXEL, REG_COL_STEP_A,    32'd0,         '{7'd0,   7'd2,   1'b0}, 1'b1,
      '{8'd0, 8'd254, 8'd0}},
    '{DIR_PIXEL, REG_COL_STEP_A,    32'd0,         '{7'd0,   7'd1,   1'b0}, 1'b1, FLAT},
    '{DIR_WRITE, REG_ROW_STEP_C,    32'd128,       '0, 1'b0, NO_WANT},
    '{DIR_PIXEL, REG_COL_STEP_A,    32'd0,         '{7'd3,   7'd1,   1'b0}, 1'b1,
      '{8'd255, 8'd1, 8'd64}},
    '{DIR_WRITE, REG_COL_STEP_A,    32'hFFFF_FFFF, '0, 1'b0, NO_WANT},
    '{DIR_WRITE, REG_COL_STEP_B,    32'h0000_01FF, '0, 1'b0, NO_WANT},
    '{DIR_WRITE, REG_ROW_STEP_C,    32'h0000_01FF, '0, 1'b0, NO_WANT},
    '{DIR_WRITE, REG_ROW_STEP_D,    32'h0000_01FF, '0, 1'b0, NO_WANT},
    '{DIR_WRITE, REG_FRAME_STEP_A,  32'h0000_01FF, '0, 1'b0, NO_WANT},
    '{DIR_WRITE, REG_FRAME_STEP_C,  32'h0000_01FF, '0, 1'b0, NO_WANT},
    '{DIR_WRITE, REG_START_PHASE_B, 32'h0000_01FF, '0, 1'b0, NO_WANT},
    '{DIR_WRITE, REG_START_PHASE_D, 32'h0000_01FF, '0, 1'b0, NO_WANT},
    '{DIR_PIXEL, REG_COL_STEP_A,    32'd0,         '{7'd127, 7'd127, 1'b1}, 1'b0, NO_WANT},
    '{DIR_PIXEL, REG_COL_STEP_A,    32'd0,         '{7'd0,   7'd0,   1'b1}, 1'b0, NO_WANT},
    '{DIR_PIXEL, REG_COL_STEP_A,    32'd0,         '{7'd64,  7'd64,  1'b0}, 1'b0, NO_WANT},
    '{DIR_PIXEL, REG_COL_STEP_A,    32'd0,         '{7'd1,   7'd126, 1'b1}, 1'b0, NO_WANT},
    '{DIR_PIXEL, REG_COL_STEP_A,    32'd0,         '{7'd126, 7'd1,   1'b0}, 1'b0, NO_WANT}
  };

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #2ms;
    $display("*** FAILED ***");
    $finish;
  end

  // round to a 24-bit mantissa, ties to even
  function automatic real to_single(input real v);
    real a, scale, frac;
    int  m;
    if (v == 0.0) return 0.0;
    a = (v < 0.0) ? -v : v;
    scale = 1.0;
    while (a >= 16777216.0) begin
      a = a / 2.0;
      scale = scale * 2.0;
    end
    while (a < 8388608.0) begin
      a = a * 2.0;
      scale = scale / 2.0;
    end
    m = $rtoi(a);
    frac = a - real'(m);
    if (frac > 0.5 || (frac == 0.5 && m[0])) m++;
    return (v < 0.0) ? -real'(m) * scale : real'(m) * scale;
  endfunction

  // table angle i * (360/entries) * 0.0174532, rounded exactly to single precision
  function automatic real table_angle(input int unsigned pos);
    longint unsigned num, den, quo, rem;
    int  sh;
    real r;
    num = longint'(pos) * 360 * 174532;
    den = longint'(SINE_ENTRIES) * 10000000;
    if (num == 0) return 0.0;
    sh = 0;
    while ((num << sh) < (den << 23)) sh++;
    quo = (num << sh) / den;
    rem = (num << sh) % den;
    if (2 * rem > den || (2 * rem == den && quo[0])) quo++;
    r = real'(quo);
    repeat (sh) r = r / 2.0;
    return r;
  endfunction

  task automatic fill_sine_lut();
    for (int i = 0; i < SINE_ENTRIES; i++)
      sine_lut[i] = $rtoi(to_single($sin(table_angle(i))) * 1024.0);
  endtask

  task automatic clear_shadow();
    plasma_reg[REG_COL_STEP_A]    = 9'd5;
    plasma_reg[REG_COL_STEP_B]    = 9'd3;
    plasma_reg[REG_ROW_STEP_C]    = 9'd1;
    plasma_reg[REG_ROW_STEP_D]    = 9'd3;
    plasma_reg[REG_FRAME_STEP_A]  = 9'd9;
    plasma_reg[REG_FRAME_STEP_C]  = 9'd8;
    plasma_reg[REG_START_PHASE_B] = 9'd0;
    plasma_reg[REG_START_PHASE_D] = 9'd0;
    frame_a = '0;
    frame_c = '0;
  endtask

  function automatic out_item_t plasma_color(input in_item_t px);
    logic [PHASE_W-1:0] pa, pb, pc, pd, col1, row9;
    int                 sum;
    logic [7:0]         idx;
    logic [7:0]         k4;
    out_item_t          o;
    col1 = {2'b00, px.column} + 9'd1;
    row9 = {2'b00, px.row};
    pa = frame_a + plasma_reg[REG_COL_STEP_A] * col1;
    pb = plasma_reg[REG_START_PHASE_B] + plasma_reg[REG_COL_STEP_B] * col1;
    pc = frame_c + plasma_reg[REG_ROW_STEP_C] * row9;
    pd = plasma_reg[REG_START_PHASE_D] + plasma_reg[REG_ROW_STEP_D] * row9;
    sum = sine_lut[pa] + sine_lut[pb] + sine_lut[pc] + sine_lut[pd];
    idx = 8'((sum >>> 4) + 128);
    k4  = {idx[5:0], 2'b00};
    case (pal_seg_t'(idx[7:6]))
      SEG_RISE: begin
        o.red   = k4;
        o.green = 8'd254 - k4;
      end
      SEG_HIGH: begin
        o.red   = 8'd255;
        o.green = k4 + 8'd1;
      end
      SEG_FALL: begin
        o.red   = 8'd254 - k4;
        o.green = 8'd254 - k4;
      end
      default: begin
        o.red   = 8'd0;
        o.green = k4 + 8'd1;
      end
    endcase
    o.palette_index = idx;
    return o;
  endfunction

  task automatic flag_error(input string msg);
    fail_cnt++;
    if (shown < 10) begin
      $display("%0t: %s", $realtime, msg);
      shown++;
    end
  endtask

  task automatic cfg_access(input logic wr, input cfg_reg_t sel, input logic [31:0] wd,
                            output logic [31:0] rd);
    cfg_psel    = 1'b1;
    cfg_penable = 1'b0;
    cfg_pwrite  = wr;
    cfg_paddr   = {sel, 2'b00};
    cfg_pwdata  = wd;
    @(negedge clk);
    cfg_penable = 1'b1;
    do @(posedge clk); while (!cfg_pready);
    rd = cfg_prdata;
    @(negedge clk);
    cfg_psel    = 1'b0;
    cfg_penable = 1'b0;
    cfg_pwrite  = 1'b0;
  endtask

  task automatic reg_write(input cfg_reg_t sel, input logic [31:0] wd);
    logic [31:0] rd;
    cfg_access(1'b1, sel, wd, rd);
    plasma_reg[sel] = wd[PHASE_W-1:0];
    cfg_access(1'b0, sel, '0, rd);
    if (rd !== {23'd0, plasma_reg[sel]})
      flag_error($sformatf("readback %s: expected %0d got %0h", sel.name(),
                           plasma_reg[sel], rd));
  endtask

  // offer one pixel word, apply the sender's idle gaps, update shadow state on accept
  task automatic push_pixel(input in_item_t px, input logic typed, input out_item_t want);
    out_item_t o;
    while ($urandom_range(99) < src_idle_pct) begin
      in_ch.valid = 1'b0;
      @(negedge clk);
    end
    in_ch.valid = 1'b1;
    in_ch.data  = px;
    do @(posedge clk); while (!in_ch.ready);
    o = plasma_color(px);
    pending_pixels.push_back(typed ? want : o);
    if (px.frame_end) begin
      frame_a = frame_a + plasma_reg[REG_FRAME_STEP_A];
      frame_c = frame_c + plasma_reg[REG_FRAME_STEP_C];
    end
    @(negedge clk);
  endtask

  task automatic wait_drained();
    in_ch.valid = 1'b0;
    while (pending_pixels.size() != 0) @(posedge clk);
    repeat (PIPE_SETTLE) @(negedge clk);
  endtask

  function automatic logic [31:0] pick_reg_value();
    logic [8:0] v;
    case ($urandom_range(7))
      0: v = '0;
      1: v = '1;
      default: v = 9'($urandom);
    endcase
    return {23'($urandom), v};
  endfunction

  // result side: random stalls plus an occasional long hold-off
  initial begin
    out_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        hold_left = LONG_HOLD;
        hold_req  = 1'b0;
      end
      if (hold_left > 0) begin
        out_ch.ready = 1'b0;
        hold_left--;
      end else begin
        out_ch.ready = ($urandom_range(99) >= snk_stall_pct);
      end
    end
  end

  always @(posedge clk) begin
    out_item_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (pending_pixels.size() == 0) begin
        flag_error($sformatf("unexpected word r=%0d g=%0d idx=%0d", out_ch.data.red,
                             out_ch.data.green, out_ch.data.palette_index));
      end else begin
        want = pending_pixels.pop_front();
        if (out_ch.data.red !== want.red || out_ch.data.green !== want.green ||
            out_ch.data.palette_index !== want.palette_index)
          flag_error($sformatf({"pixel mismatch: expected r=%0d g=%0d idx=%0d, ",
                                "got r=%0d g=%0d idx=%0d"},
                               want.red, want.green, want.palette_index, out_ch.data.red,
                               out_ch.data.green, out_ch.data.palette_index));
      end
    end
  end

  initial begin
    in_item_t   px;
    idle_mode_t mode;
    int         run_left;
    logic [6:0] cur_row, cur_col;

    rst_n       = 1'b0;
    in_ch.valid = 1'b0;
    in_ch.data  = '0;
    cfg_psel    = 1'b0;
    cfg_penable = 1'b0;
    cfg_pwrite  = 1'b0;
    cfg_paddr   = '0;
    cfg_pwdata  = '0;
    fill_sine_lut();
    clear_shadow();
    repeat (8) @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    foreach (dir_tab[i]) begin
      if (dir_tab[i].op == DIR_WRITE) begin
        wait_drained();
        reg_write(dir_tab[i].sel, dir_tab[i].wdata);
      end else begin
        push_pixel(dir_tab[i].px, dir_tab[i].typed, dir_tab[i].want);
      end
    end

    for (int ph = 0; ph < PHASES; ph++) begin
      wait_drained();
      for (int r = 0; r < 8; r++) reg_write(cfg_reg_t'(r), pick_reg_value());
      mode = idle_mode_t'(ph % 4);
      src_idle_pct  = (mode == IDLE_SRC) ? 80 : (mode == IDLE_BOTH) ? 13 : 0;
      snk_stall_pct = (mode == IDLE_SNK) ? 80 : (mode == IDLE_BOTH) ? 13 : 0;
      run_left = 0;
      cur_row  = '0;
      cur_col  = '0;
      for (int n = 0; n < PHASE_PIXELS; n++) begin
        if (n == 60) hold_req = 1'b1;
        // sender pause until every word is back
        if (n == 140) wait_drained();
        if (run_left == 0 && $urandom_range(3) == 0) begin
          px = in_item_t'(15'($urandom));
        end else begin
          // raster run across the row, frame_end on its last word
          if (run_left == 0) begin
            run_left = $urandom_range(4, 24);
            cur_row  = 7'($urandom);
            cur_col  = 7'($urandom);
          end
          run_left--;
          px.row       = cur_row;
          px.column    = cur_col;
          px.frame_end = (run_left == 0);
          cur_col++;
          if (cur_col == 0) cur_row++;
        end
        push_pixel(px, 1'b0, NO_WANT);
      end
    end

    wait_drained();
    if (fail_cnt == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

@@ sim.f @@
src/ppg_pkg.sv
src/ppg_if.sv
src/ppg_sine_rom.sv
src/plasma_pixel_generator_top.sv
tb/sv/plasma_pixel_generator_top_tb.sv
